>>> src/address_range_coalescing_table_top_assert.svh
// assertion macros for the range coalescing table
// used by address_range_coalescing_table_top; expects clk and rst_n in scope
`ifndef ADDRESS_RANGE_COALESCING_TABLE_TOP_ASSERT_SVH
`define ADDRESS_RANGE_COALESCING_TABLE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ARCT_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("arct assertion failed");
`define ARCT_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arct assertion failed");
`else
`define ARCT_ASSERT(name, prop)
`define ARCT_ASSERT_IMP(name, ante, cons)
`endif
`endif

>>> src/arct_pkg.sv
// shared types and codes of the range coalescing table
// no dependencies; imported by arct_cell, address_range_coalescing_table_top and the testbench
package arct_pkg;

    localparam int ADDR_W   = 64;
    localparam int PERM_W   = 8;
    localparam int STATUS_W = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_FULL    = 3'd2,
        ST_REGION  = 3'd3,
        ST_EMPTY   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD  = 3'd0,
        CELL_CMP   = 3'd1,
        CELL_APPLY = 3'd2,
        CELL_MERGE = 3'd3,
        CELL_SHIFT = 3'd4
    } cell_cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] stop;
        logic [PERM_W-1:0] perm;
    } entry_t;

    typedef struct packed {
        logic valid;
        logic bef;
        logic ov;
        logic dead;
    } cell_flags_t;

    typedef struct packed {
        cell_cmd_t cmd;
        logic      any_ov;
    } cell_ctrl_t;

endpackage

>>> src/arct_cell.sv
// one slot of the sorted range chain: holds a range, compares it with a new range,
// takes part in insert, absorb and drain shifts; depends on arct_pkg
module arct_cell import arct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cell_ctrl_t  ctrl,
    input  entry_t      nw,
    input  entry_t      left_ent,
    input  cell_flags_t left_flg,
    input  entry_t      right_ent,
    input  cell_flags_t right_flg,
    output entry_t      ent,
    output cell_flags_t flg
);

    entry_t ent_reg, ent_next;
    logic   valid_reg, valid_next;
    logic   bef_reg, bef_next;
    logic   ov_reg, ov_next;
    logic   dead_reg, dead_next;
    logic   lt_reg, lt_next;
    logic   gt_reg, gt_next;
    logic   surv_reg, surv_next;
    logic   first;

    // first overlapping slot of the run keeps the merged range
    assign first = ov_reg & ~left_flg.ov;

    always_comb
    begin
        ent_next   = ent_reg;
        valid_next = valid_reg;
        bef_next   = bef_reg;
        ov_next    = ov_reg;
        dead_next  = dead_reg;
        lt_next    = lt_reg;
        gt_next    = gt_reg;
        surv_next  = surv_reg;
        unique case (ctrl.cmd)
            CELL_HOLD:
            begin
            end
            CELL_CMP:
            begin
                bef_next = valid_reg & (ent_reg.stop <= nw.start);
                ov_next  = valid_reg & ~(ent_reg.stop <= nw.start)
                           & ~(nw.stop <= ent_reg.start);
                lt_next  = ent_reg.start < nw.start;
                gt_next  = ent_reg.stop > nw.stop;
            end
            CELL_APPLY:
            begin
                if (ctrl.any_ov)
                begin
                    surv_next = first;
                    dead_next = ov_reg & ~first;
                    if (first)
                    begin
                        ent_next.start = lt_reg ? ent_reg.start : nw.start;
                        ent_next.stop  = gt_reg ? ent_reg.stop : nw.stop;
                        ent_next.perm  = ent_reg.perm | nw.perm;
                    end
                end
                else
                begin
                    surv_next = 1'b0;
                    dead_next = 1'b0;
                    // slots past the insert point move up by one
                    if (!bef_reg)
                    begin
                        if (left_flg.bef)
                        begin
                            ent_next   = nw;
                            valid_next = 1'b1;
                        end
                        else
                        begin
                            ent_next   = left_ent;
                            valid_next = left_flg.valid;
                        end
                    end
                end
            end
            CELL_MERGE:
            begin
                if (surv_reg)
                begin
                    if (right_flg.dead)
                    begin
                        if (right_ent.stop > ent_reg.stop)
                        begin
                            ent_next.stop = right_ent.stop;
                        end
                        ent_next.perm = ent_reg.perm | right_ent.perm;
                    end
                end
                else if (!bef_reg)
                begin
                    ent_next   = right_ent;
                    valid_next = right_flg.valid;
                    dead_next  = right_flg.dead;
                end
            end
            CELL_SHIFT:
            begin
                ent_next   = right_ent;
                valid_next = right_flg.valid;
                dead_next  = right_flg.dead;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            bef_reg   <= 1'b0;
            ov_reg    <= 1'b0;
            dead_reg  <= 1'b0;
            lt_reg    <= 1'b0;
            gt_reg    <= 1'b0;
            surv_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            bef_reg   <= bef_next;
            ov_reg    <= ov_next;
            dead_reg  <= dead_next;
            lt_reg    <= lt_next;
            gt_reg    <= gt_next;
            surv_reg  <= surv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign ent       = ent_reg;
    assign flg.valid = valid_reg;
    assign flg.bef   = bef_reg;
    assign flg.ov    = ov_reg;
    assign flg.dead  = dead_reg;

endmodule

>>> src/address_range_coalescing_table_top.sv
// insert: compare in the transfer cycle, then apply, which registers the result once the output is free;
// an overlapping insert then merges, absorbing one stored range at a time, before the next transfer.
// drain: one result per cycle from slot 0 of the chain while the output is not stalled; EMPTY if empty.
// an input transfer is taken only in the idle state, after the steps of the previous request end.
// rst_n (async, active low) clears the valid bit of every slot: the table starts empty.
// depends on arct_pkg, arct_cell and address_range_coalescing_table_top_assert.svh
`include "address_range_coalescing_table_top_assert.svh"
module address_range_coalescing_table_top import arct_pkg::*;
#(
    parameter int MAX_REGIONS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // range_base[63:0], range_end[127:64], range_flags[135:128]
    input  logic [0:0]   s_tuser,   // opcode[0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // region_start[63:0], region_stop[127:64], region_perm[135:128]
    output logic [2:0]   m_tuser,   // status[2:0]
    output logic         m_tlast
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_APPLY = 4'b0010,
        S_MERGE = 4'b0100,
        S_DRAIN = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    entry_t      ent_vec [MAX_REGIONS];
    cell_flags_t flg_vec [MAX_REGIONS];
    logic [MAX_REGIONS-1:0] valid_vec;
    logic [MAX_REGIONS-1:0] ov_vec;
    logic [MAX_REGIONS-1:0] dead_vec;
    logic [MAX_REGIONS-1:0] valid_inc;
    logic [MAX_REGIONS:0]   valid_ext;

    entry_t     bus_ent;
    entry_t     new_reg;
    entry_t     nw;
    logic       inv_reg;
    cell_ctrl_t ctrl;
    logic       any_ov;
    logic       any_dead;
    logic       accept;

    logic       out_valid_reg, out_valid_next;
    entry_t     out_ent_reg;
    status_t    out_status_reg;
    logic       out_last_reg;
    logic       out_free;

    logic       push;
    status_t    push_status;
    entry_t     push_ent;
    logic       push_last;

    assign bus_ent.start = s_tdata[63:0];
    assign bus_ent.stop  = s_tdata[127:64];
    assign bus_ent.perm  = s_tdata[135:128];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid & s_tready;
    // cells compare against the bus in the transfer cycle, later against the latched copy
    assign nw       = (state_reg == S_IDLE) ? bus_ent : new_reg;

    genvar i;
    generate
        for (i = 0; i < MAX_REGIONS; i++)
        begin : g_cell
            entry_t      l_ent;
            entry_t      r_ent;
            cell_flags_t l_flg;
            cell_flags_t r_flg;

            if (i == 0)
            begin : g_head
                assign l_ent = '0;
                assign l_flg = '{valid: 1'b0, bef: 1'b1, ov: 1'b0, dead: 1'b0};
            end
            else
            begin : g_mid_l
                assign l_ent = ent_vec[i-1];
                assign l_flg = flg_vec[i-1];
            end

            if (i == MAX_REGIONS - 1)
            begin : g_tail
                assign r_ent = '0;
                assign r_flg = '0;
            end
            else
            begin : g_mid_r
                assign r_ent = ent_vec[i+1];
                assign r_flg = flg_vec[i+1];
            end

            arct_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .nw        (nw),
                .left_ent  (l_ent),
                .left_flg  (l_flg),
                .right_ent (r_ent),
                .right_flg (r_flg),
                .ent       (ent_vec[i]),
                .flg       (flg_vec[i])
            );

            assign valid_vec[i] = flg_vec[i].valid;
            assign ov_vec[i]    = flg_vec[i].ov;
            assign dead_vec[i]  = flg_vec[i].dead;
        end
    endgenerate

    assign valid_ext = {1'b0, valid_vec};
    assign valid_inc = valid_vec + MAX_REGIONS'(1);
    assign any_ov    = |ov_vec;
    assign any_dead  = |dead_vec;
    assign out_free  = ~out_valid_reg | m_tready;

    always_comb
    begin
        state_next  = state_reg;
        ctrl.cmd    = CELL_HOLD;
        ctrl.any_ov = any_ov;
        push        = 1'b0;
        push_status = ST_OK;
        push_ent    = '0;
        push_last   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser[0])
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        ctrl.cmd   = CELL_CMP;
                        state_next = S_APPLY;
                    end
                end
            end
            S_APPLY:
            begin
                if (out_free)
                begin
                    push       = 1'b1;
                    state_next = S_IDLE;
                    if (inv_reg)
                    begin
                        push_status = ST_INVALID;
                    end
                    else if (!any_ov && valid_vec[MAX_REGIONS-1])
                    begin
                        push_status = ST_FULL;
                    end
                    else
                    begin
                        push_status = ST_OK;
                        ctrl.cmd    = CELL_APPLY;
                        if (any_ov)
                        begin
                            state_next = S_MERGE;
                        end
                    end
                end
            end
            S_MERGE:
            begin
                // one absorbed range leaves the chain per cycle
                if (any_dead)
                begin
                    ctrl.cmd = CELL_MERGE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DRAIN:
            begin
                if (out_free)
                begin
                    push = 1'b1;
                    if (!valid_vec[0])
                    begin
                        push_status = ST_EMPTY;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        push_status = ST_REGION;
                        push_ent    = ent_vec[0];
                        push_last   = ~valid_ext[1];
                        ctrl.cmd    = CELL_SHIFT;
                        if (!valid_ext[1])
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            new_reg <= bus_ent;
            inv_reg <= ~(bus_ent.stop > bus_ent.start);
        end
        if (push)
        begin
            out_ent_reg    <= push_ent;
            out_status_reg <= push_status;
            out_last_reg   <= push_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_ent_reg.perm, out_ent_reg.stop, out_ent_reg.start};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    // occupied slots always form a block starting at slot 0
    `ARCT_ASSERT(a_valid_prefix, (valid_vec & valid_inc) == '0)
    // absorbed ranges are pending only while merging
    `ARCT_ASSERT_IMP(a_dead_in_merge, state_reg != S_MERGE, dead_vec == '0)
    // the apply step follows an insert transfer or a stalled apply
    `ARCT_ASSERT_IMP(a_apply_entry, state_reg == S_APPLY,
        $past(accept) || $past(state_reg == S_APPLY))

endmodule

>>> sim/tb_address_range_coalescing_table_top.sv
// self-checking testbench for address_range_coalescing_table_top
// needs arct_pkg and the table rtl; a scoreboard class predicts every region and status
`timescale 1ns / 100ps
module tb_address_range_coalescing_table_top import arct_pkg::*;
;

    localparam int TABLE_DEPTH = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 60;
    localparam int PHASE_ITEMS = 125;
    localparam int HOLD_ITEMS = 30;
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DRAIN = 1'b1;
    localparam logic [63:0] ADDR_MAX = '1;

    typedef struct packed {
        logic        op;
        logic [63:0] base;
        logic [63:0] lim;
        logic [7:0]  flags;
    } range_req_t;

    typedef struct packed {
        status_t     status;
        logic [63:0] start;
        logic [63:0] stop;
        logic [7:0]  perm;
        logic        last;
    } region_t;

    class region_table_predictor;
        logic [63:0] slot_start[TABLE_DEPTH];
        logic [63:0] slot_stop[TABLE_DEPTH];
        logic [7:0]  slot_perm[TABLE_DEPTH];
        int unsigned slot_count;
        region_t     pending_regions[$];
        int unsigned failures;

        function new();
            slot_count = 0;
            failures = 0;
        endfunction

        function void push_region(status_t st, logic [63:0] a, logic [63:0] b,
                                  logic [7:0] p, logic fin);
            region_t r;
            r.status = st;
            r.start = a;
            r.stop = b;
            r.perm = p;
            r.last = fin;
            pending_regions.push_back(r);
        endfunction

        // absorb every strictly overlapping slot, then append the union
        function void insert_range(logic [63:0] base, logic [63:0] lim, logic [7:0] flags);
            bit          gone[TABLE_DEPTH];
            int unsigned kept;
            bit          grew;
            logic [63:0] lo;
            logic [63:0] hi;
            logic [7:0]  pm;
            int          w;
            lo = base;
            hi = lim;
            pm = flags;
            if (hi <= lo)
            begin
                push_region(ST_INVALID, '0, '0, '0, 1'b1);
                return;
            end
            foreach (gone[i]) gone[i] = 1'b0;
            kept = slot_count;
            grew = 1'b1;
            while (grew)
            begin
                grew = 1'b0;
                for (int i = 0; i < slot_count; i++)
                begin
                    if (!gone[i] && !(hi <= slot_start[i] || slot_stop[i] <= lo))
                    begin
                        if (slot_start[i] < lo) lo = slot_start[i];
                        if (slot_stop[i] > hi) hi = slot_stop[i];
                        pm = pm | slot_perm[i];
                        gone[i] = 1'b1;
                        kept--;
                        grew = 1'b1;
                    end
                end
            end
            if (kept >= TABLE_DEPTH)
            begin
                push_region(ST_FULL, '0, '0, '0, 1'b1);
                return;
            end
            w = 0;
            for (int i = 0; i < slot_count; i++)
            begin
                if (!gone[i])
                begin
                    slot_start[w] = slot_start[i];
                    slot_stop[w] = slot_stop[i];
                    slot_perm[w] = slot_perm[i];
                    w++;
                end
            end
            slot_start[w] = lo;
            slot_stop[w] = hi;
            slot_perm[w] = pm;
            slot_count = w + 1;
            push_region(ST_OK, '0, '0, '0, 1'b1);
        endfunction

        function void drain_sorted();
            bit sent[TABLE_DEPTH];
            int best;
            if (slot_count == 0)
            begin
                push_region(ST_EMPTY, '0, '0, '0, 1'b1);
                return;
            end
            foreach (sent[i]) sent[i] = 1'b0;
            for (int k = 0; k < slot_count; k++)
            begin
                best = -1;
                for (int i = 0; i < slot_count; i++)
                    if (!sent[i] && (best < 0 || slot_start[i] < slot_start[best]))
                        best = i;
                sent[best] = 1'b1;
                push_region(ST_REGION, slot_start[best], slot_stop[best], slot_perm[best],
                            k == slot_count - 1);
            end
            slot_count = 0;
        endfunction

        function void take_request(range_req_t r);
            if (r.op == OP_DRAIN)
                drain_sorted();
            else
                insert_range(r.base, r.lim, r.flags);
        endfunction

        function void report(string what, region_t exp, region_t got);
            failures++;
            if (failures <= 10)
                $display({"%s: expected st %0d start %h stop %h perm %h last %b, ",
                          "got st %0d start %h stop %h perm %h last %b"},
                         what, exp.status, exp.start, exp.stop, exp.perm, exp.last,
                         got.status, got.start, got.stop, got.perm, got.last);
        endfunction

        function void compare_region(region_t got);
            region_t exp;
            if (pending_regions.size() == 0)
            begin
                report("unexpected transfer", '0, got);
                return;
            end
            exp = pending_regions.pop_front();
            if (got !== exp)
                report("mismatch", exp, got);
        endfunction

        function int outstanding();
            return pending_regions.size();
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    region_table_predictor table_sb;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_requests;
    int unsigned hold_taken;
    int unsigned hold_left;
    int unsigned quiet_cycles;

    address_range_coalescing_table_top #(.MAX_REGIONS(TABLE_DEPTH)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // receiver: random backpressure, or a long hold when one is requested
    always @(negedge clk)
    begin
        if (hold_taken != hold_requests)
        begin
            hold_taken = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        region_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status = status_t'(m_tuser);
            got.start = m_tdata[63:0];
            got.stop = m_tdata[127:64];
            got.perm = m_tdata[135:128];
            got.last = m_tlast;
            table_sb.compare_region(got);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic range_req_t mk_req(logic op, logic [63:0] base, logic [63:0] lim,
                                          logic [7:0] flags);
        range_req_t r;
        r.op = op;
        r.base = base;
        r.lim = lim;
        r.flags = flags;
        return r;
    endfunction

    // mostly clustered inserts so that ranges overlap and the table fills
    function automatic range_req_t random_request(logic [63:0] window);
        range_req_t  r;
        int unsigned pick;
        pick = $urandom_range(99);
        r.op = OP_INSERT;
        r.flags = 8'($urandom_range(255));
        r.base = {$urandom, $urandom};
        r.lim = {$urandom, $urandom};
        if (pick < 7)
            r.op = OP_DRAIN;
        else if (pick < 70)
        begin
            r.base = window + $urandom_range(400);
            r.lim = r.base + $urandom_range(1, 40);
        end
        else if (pick < 80)
            r.lim = r.base - $urandom_range(3);
        else if (pick < 88)
        begin
            r.lim = ADDR_MAX - $urandom_range(20);
            r.base = r.lim - $urandom_range(1, 30);
        end
        return r;
    endfunction

    task automatic send_item(range_req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {r.flags, r.lim, r.base};
        s_tuser <= r.op;
        do
            @(posedge clk);
        while (!s_tready);
        table_sb.take_request(r);
    endtask

    task automatic wait_for_regions();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (table_sb.outstanding() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [63:0] window;
        table_sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests = 0;
        hold_taken = 0;
        hold_left = 0;
        quiet_cycles = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty drain, empty ranges, extremes, touching, multi-absorb, full table
        send_item(mk_req(OP_DRAIN, '0, '0, 8'h00));
        send_item(mk_req(OP_INSERT, '0, '0, 8'hFF));
        send_item(mk_req(OP_INSERT, ADDR_MAX, '0, 8'h5A));
        send_item(mk_req(OP_INSERT, ADDR_MAX, ADDR_MAX, 8'hA5));
        send_item(mk_req(OP_INSERT, 64'd0, 64'd1, 8'h00));
        send_item(mk_req(OP_INSERT, ADDR_MAX - 1, ADDR_MAX, 8'hFF));
        send_item(mk_req(OP_INSERT, 64'd1, 64'd2, 8'h01));
        send_item(mk_req(OP_INSERT, 64'd0, 64'd3, 8'h80));
        for (int k = 1; k <= 14; k++)
            send_item(mk_req(OP_INSERT, 64'(16 * k), 64'(16 * k + 4), 8'(k)));
        send_item(mk_req(OP_INSERT, 64'd3, 64'd4, 8'h02));
        send_item(mk_req(OP_INSERT, 64'd2, 64'd5, 8'h04));
        send_item(mk_req(OP_DRAIN, ADDR_MAX, ADDR_MAX, 8'hFF));
        wait_for_regions();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 80 : 0;
            recv_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 23 : 0;
            window = {1'b0, 31'($urandom), $urandom};
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_item(random_request(window));
                if (phase == 2 && n == PHASE_ITEMS / 2)
                begin
                    // stall the output and keep offering inserts until the input backs up
                    hold_requests++;
                    for (int j = 0; j < HOLD_ITEMS; j++)
                    begin
                        window = window + 64'd4096;
                        send_item(mk_req(OP_INSERT, window, window + $urandom_range(1, 20),
                                         8'($urandom_range(255))));
                    end
                    wait_for_regions();
                end
            end
            wait_for_regions();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (table_sb.failures == 0 && table_sb.outstanding() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/arct_pkg.sv
src/arct_cell.sv
src/address_range_coalescing_table_top.sv
sim/tb_address_range_coalescing_table_top.sv
